// ===== sv/cpf_pkg.sv =====
// Package for the complementary pitch filter: payload structs, register codes,
// CORDIC angle table. No dependencies.
`default_nettype none
package cpf_pkg;
   typedef struct packed {
      logic [31:0]        sample_time_us;
      logic signed [15:0] gyro_rate;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_z;
      logic               accel_plausible;
   } req_type;

   typedef struct packed {
      logic signed [23:0] filtered_pitch;
      logic signed [23:0] tilt_pitch;
      logic signed [15:0] pitch_rate;
      logic [31:0]        step_us;
      logic               estimate_valid;
      logic               update_ok;
   } rsp_type;

   typedef enum logic [1:0] {
      REG_MIN_STEP = 2'd0, REG_MAX_STEP = 2'd1, REG_WEIGHT = 2'd2, REG_OFFSET = 2'd3
   } reg_index_type;

   // CORDIC vector state handed from cell to cell
   typedef struct packed {
      logic signed [26:0] x;
      logic signed [26:0] y;
      logic signed [29:0] ang;
   } vec_type;

   localparam int TABLE_LEN = 24;
   localparam int TABLE_FRAC = 20;
   // output angle resolution; the gyro datapath widths are sized for this value
   localparam int ANGLE_FRACTION_BITS = 8;

   function automatic logic signed [29:0] atan_entry(input int i);
      logic signed [29:0] t [TABLE_LEN] = '{
         30'sd47185920, 30'sd27855475, 30'sd14718068, 30'sd7471121, 30'sd3750058,
         30'sd1876857, 30'sd938658, 30'sd469357, 30'sd234682, 30'sd117342,
         30'sd58671, 30'sd29335, 30'sd14668, 30'sd7334, 30'sd3667, 30'sd1833,
         30'sd917, 30'sd458, 30'sd229, 30'sd115, 30'sd57, 30'sd29, 30'sd14, 30'sd7};
      return t[i];
   endfunction
endpackage
`default_nettype wire

// ===== sv/cpf_cordic_cell.sv =====
// One CORDIC vectoring cell: a fixed micro-rotation with a registered output.
// Depends on cpf_pkg.
`default_nettype none
module cpf_cordic_cell #(
   parameter int STEP = 0
) (
   input  wire logic             clock,
   input  wire cpf_pkg::vec_type vec_in,
   output cpf_pkg::vec_type      vec_out
);
   import cpf_pkg::*;
   vec_type vec_ff, vec_rot_in;

   // rotate toward y = 0; arithmetic shift is floor
   always_comb begin
      vec_rot_in = vec_in;
      if (!vec_in.y[26]) begin
         vec_rot_in.x   = vec_in.x + (vec_in.y >>> STEP);
         vec_rot_in.y   = vec_in.y - (vec_in.x >>> STEP);
         vec_rot_in.ang = vec_in.ang + atan_entry(STEP);
      end else begin
         vec_rot_in.x   = vec_in.x - (vec_in.y >>> STEP);
         vec_rot_in.y   = vec_in.y + (vec_in.x >>> STEP);
         vec_rot_in.ang = vec_in.ang - atan_entry(STEP);
      end
   end

   always_ff @(posedge clock) vec_ff <= vec_rot_in;
   assign vec_out = vec_ff;
endmodule
`default_nettype wire

// ===== sv/complementary_pitch_filter.sv =====
// Complementary pitch filter for one IMU axis.
// Channels: req_ (one IMU sample per item), rsp_ (one result per item),
// csr_ (register writes: 0 min step, 1 max step, 2 gyro weight, 3 offset).
// One item at a time: req_ready is high only when the block is empty.
// After acceptance, the CORDIC vector walks a row of CORDIC_STEPS registered
// cells (at most TABLE_LEN), then the step check, gyro increment multiply, two
// reciprocal divide stages, the quotient correction and the blend take one
// registered stage each before rsp_valid rises.
// The next item is taken in the cycle after the result is taken, so a new
// item is never accepted while one is in flight.
// Reset (synchronous, high) restores register defaults and clears the
// stored timestamp (not started) and pitch estimate.
// A stalled receiver holds the result in rsp_payload; nothing is lost.
`default_nettype none
module complementary_pitch_filter #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire cpf_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output cpf_pkg::rsp_type  rsp_payload,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [19:0]  csr_data
);
   import cpf_pkg::*;
   localparam int NC = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
   localparam int SH = TABLE_FRAC - ANGLE_FRACTION_BITS;
   localparam int LAT = NC + 6;
   localparam int CW = $clog2(LAT + 1);

   logic [19:0] min_ff, max_ff;
   logic [16:0] weight_ff;
   logic signed [16:0] offset_ff;
   logic [31:0] prev_ff;
   logic signed [23:0] est_ff;
   logic busy_ff;
   logic [CW-1:0] cnt_ff;
   logic out_ff;
   req_type item_ff;
   rsp_type rsp_ff;

   assign csr_ready = 1'b1;
   assign req_ready = !busy_ff;
   assign rsp_valid = out_ff;
   assign rsp_payload = rsp_ff;

   // CORDIC prerotation and cell row
   vec_type chain [NC+1];
   vec_type start_vec;
   logic zero_vec;
   always_comb begin
      start_vec.x   = 27'(signed'(item_ff.accel_z)) <<< 8;
      start_vec.y   = 27'(signed'(item_ff.accel_x)) <<< 8;
      start_vec.ang = '0;
      if (item_ff.accel_z[15]) begin
         start_vec.ang = item_ff.accel_x[15] ? -30'sd188743680 : 30'sd188743680;
         start_vec.x   = -start_vec.x;
         start_vec.y   = -start_vec.y;
      end
   end
   assign chain[0] = start_vec;
   assign zero_vec = (item_ff.accel_x == '0) && (item_ff.accel_z == '0);

   for (genvar g = 0; g < NC; g++) begin : g_cell
      cpf_cordic_cell #(.STEP(g)) u_cell (.clock(clock), .vec_in(chain[g]),
         .vec_out(chain[g+1]));
   end

   // stage A: accelerometer pitch and step window check
   logic signed [29:0] ang_r;
   logic signed [31:0] raw_sum;
   logic signed [23:0] raw_ff;
   logic [31:0] step_ff, step_n;
   logic restart_ff, okr_ff;
   assign ang_r = (chain[NC].ang + (30'sd1 <<< (SH - 1))) >>> SH;
   assign raw_sum = (zero_vec ? 32'sd0 : 32'(ang_r)) + 32'(offset_ff);
   assign step_n = item_ff.sample_time_us - prev_ff;

   // stage B: product magnitude
   logic [55:0] mag_ff;
   logic neg_ff;
   logic [31:0] delta_ff;
   logic signed [47:0] prod;
   assign prod = 48'(signed'(item_ff.gyro_rate)) * $signed({16'd0, step_ff});

   // stages C to E: floor(num / 16e6) = floor(num/2^10 / 15625); the quotient
   // estimate from a 32-bit reciprocal is at most one low, fixed by the remainder
   localparam logic [31:0] RECIP = 32'd2251799813;  // floor(2^45 / 15625)
   logic [55:0] num;
   logic [45:0] q0;
   logic [54:0] pp_hi_ff, pp_lo_ff;
   logic [77:0] qsum;
   logic [31:0] qe_ff;
   logic [45:0] rem;
   assign num = mag_ff + 56'd8000000;
   assign q0 = num[55:10];
   assign qsum = {pp_hi_ff, 23'd0} + 78'(pp_lo_ff);
   assign rem = q0 - 46'(qe_ff) * 46'd15625;

   // stage F: blend
   logic signed [17:0] w;
   assign w = (weight_ff > 17'd65536) ? 18'sd65536 : signed'({1'b0, weight_ff});
   logic signed [33:0] integ;
   logic signed [53:0] s;
   logic signed [37:0] sh16;
   assign integ = 34'(est_ff) + (neg_ff ? -34'(signed'({1'b0, delta_ff}))
                                       : 34'(signed'({1'b0, delta_ff})));
   assign s = 54'(w) * 54'(integ) + (54'sd65536 - 54'(w)) * 54'(raw_ff) + 54'sd32768;
   assign sh16 = 38'(s >>> 16);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= 20'd500; max_ff <= 20'd50000;
         weight_ff <= 17'd64225; offset_ff <= '0;
         prev_ff <= '0; est_ff <= '0; busy_ff <= 1'b0; out_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (csr_valid) begin
            unique case (reg_index_type'(csr_index))
               REG_MIN_STEP: min_ff <= csr_data;
               REG_MAX_STEP: max_ff <= csr_data;
               REG_WEIGHT:   weight_ff <= {1'b0, csr_data[15:0]} |
                                          {csr_data[16], 16'd0};
               REG_OFFSET:   offset_ff <= signed'(csr_data[16:0]);
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) out_ff <= 1'b0;
         if (req_valid && req_ready) begin
            item_ff <= req_payload; busy_ff <= 1'b1; cnt_ff <= '0;
         end else if (busy_ff && !out_ff) begin
            cnt_ff <= cnt_ff + CW'(1);
            if (cnt_ff == CW'(NC)) begin
               raw_ff <= (raw_sum > 32'sd8388607) ? 24'sd8388607 :
                         (raw_sum < -32'sd8388608) ? -24'sd8388608 : 24'(raw_sum);
               step_ff <= step_n;
               restart_ff <= (prev_ff == '0) || (step_n < 32'(min_ff)) ||
                             (step_n > 32'(max_ff));
               okr_ff <= (prev_ff == '0) ? item_ff.accel_plausible : 1'b0;
            end
            if (cnt_ff == CW'(NC + 1)) begin
               neg_ff <= prod[47];
               mag_ff <= 56'(prod[47] ? -prod : prod) << ANGLE_FRACTION_BITS;
            end
            if (cnt_ff == CW'(NC + 2)) begin
               pp_hi_ff <= 55'(q0[45:23]) * 55'(RECIP);
               pp_lo_ff <= 55'(q0[22:0]) * 55'(RECIP);
            end
            if (cnt_ff == CW'(NC + 3))
               qe_ff <= qsum[76:45];
            if (cnt_ff == CW'(NC + 4))
               delta_ff <= (rem >= 46'd15625) ? qe_ff + 32'd1 : qe_ff;
            if (cnt_ff == CW'(LAT - 1)) begin
               prev_ff <= item_ff.sample_time_us;
               rsp_ff.tilt_pitch <= raw_ff;
               rsp_ff.pitch_rate <= item_ff.gyro_rate;
               rsp_ff.estimate_valid <= item_ff.accel_plausible;
               out_ff <= 1'b1;
               if (restart_ff) begin
                  est_ff <= raw_ff; rsp_ff.filtered_pitch <= raw_ff;
                  rsp_ff.step_us <= '0; rsp_ff.update_ok <= okr_ff;
               end else begin
                  est_ff <= (sh16 > 38'sd8388607) ? 24'sd8388607 :
                            (sh16 < -38'sd8388608) ? -24'sd8388608 : 24'(sh16);
                  rsp_ff.filtered_pitch <= (sh16 > 38'sd8388607) ? 24'sd8388607 :
                            (sh16 < -38'sd8388608) ? -24'sd8388608 : 24'(sh16);
                  rsp_ff.step_us <= step_ff; rsp_ff.update_ok <= item_ff.accel_plausible;
               end
            end
         end else if (out_ff && rsp_ready) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // a result is only shown while an item is in flight
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy_ff)
      else $error("result without item");
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready) else $error("second item taken");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_payload)) else $error("result changed");
endmodule
`default_nettype wire

// ===== dv/complementary_pitch_filter_test.sv =====
// Testbench for complementary_pitch_filter: directed and random IMU samples,
// results checked against an in-bench fixed-point filter predictor.
// Depends on cpf_pkg and the complementary_pitch_filter RTL.
`default_nettype none
module complementary_pitch_filter_test;
   import cpf_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [19:0] csr_data = '0;

   complementary_pitch_filter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // filter state and register copy
   logic [31:0] last_stamp;
   longint      pitch_state;
   logic [31:0] min_step, max_step;
   longint      weight, offset;
   logic [31:0] stamp;          // timestamp of the next generated sample
   rsp_type     pending_results[$];
   int          errors = 0;
   bit          quiet = 0;      // no idling on either side while set

   localparam longint ATAN_DEG [16] = '{
      47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
      234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833};

   function automatic longint clamp24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   // vectoring CORDIC, angle in 2^-20 degree, rounded to 1/256 degree
   function automatic longint accel_angle(logic signed [15:0] ax, logic signed [15:0] az);
      longint x, y, ang, dx, dy;
      x = longint'(az) * 256;
      y = longint'(ax) * 256;
      ang = 0;
      if (ax != 0 || az != 0) begin
         if (x < 0) begin
            ang = (y >= 0) ? (longint'(180) <<< 20) : -(longint'(180) <<< 20);
            x = -x;
            y = -y;
         end
         for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x += dx; y -= dy; ang += ATAN_DEG[i];
            end else begin
               x -= dx; y += dy; ang -= ATAN_DEG[i];
            end
         end
         ang = (ang + 2048) >>> 12;
      end
      return clamp24(ang + offset);
   endfunction

   function automatic rsp_type predict_pitch(req_type s);
      longint raw, prod, mag, delta, w, sum;
      logic [31:0] st;
      rsp_type r;
      raw = accel_angle(s.accel_x, s.accel_z);
      st = s.sample_time_us - last_stamp;
      r.tilt_pitch = raw[23:0];
      r.pitch_rate = s.gyro_rate;
      r.estimate_valid = s.accel_plausible;
      r.update_ok = s.accel_plausible;
      r.step_us = '0;
      if (last_stamp == 0 || st < min_step || st > max_step) begin
         // restart from the accelerometer angle
         if (last_stamp != 0) r.update_ok = 1'b0;
         pitch_state = raw;
      end else begin
         prod = longint'(s.gyro_rate) * longint'(st);
         mag = (prod < 0) ? -prod : prod;
         delta = (mag * 256 + 8000000) / 16000000;
         if (prod < 0) delta = -delta;
         w = (weight > 65536) ? 65536 : weight;
         sum = w * (pitch_state + delta) + (65536 - w) * raw + 32768;
         pitch_state = clamp24(sum >>> 16);
         r.step_us = st;
      end
      last_stamp = s.sample_time_us;
      r.filtered_pitch = pitch_state[23:0];
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // result checker with random receiver stalls
   int stall_left = 0;
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_payload.filtered_pitch !== want.filtered_pitch)
                  report_mismatch("filtered_pitch", rsp_payload.filtered_pitch,
                                  want.filtered_pitch);
               if (rsp_payload.tilt_pitch !== want.tilt_pitch)
                  report_mismatch("tilt_pitch", rsp_payload.tilt_pitch, want.tilt_pitch);
               if (rsp_payload.pitch_rate !== want.pitch_rate)
                  report_mismatch("pitch_rate", rsp_payload.pitch_rate, want.pitch_rate);
               if (rsp_payload.step_us !== want.step_us)
                  report_mismatch("step_us", rsp_payload.step_us, want.step_us);
               if (rsp_payload.estimate_valid !== want.estimate_valid)
                  report_mismatch("estimate_valid", rsp_payload.estimate_valid,
                                  want.estimate_valid);
               if (rsp_payload.update_ok !== want.update_ok)
                  report_mismatch("update_ok", rsp_payload.update_ok, want.update_ok);
            end
            stall_left = quiet ? 0 : $urandom_range(0, 18);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // send one sample; valid stays up if the next item follows at once
   task automatic send_sample(req_type s);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= s;
      do @(posedge clock); while (!req_ready);
      pending_results.push_back(predict_pitch(s));
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [19:0] value);
      drain();
      repeat (30) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_MIN_STEP: min_step = 32'(value);
         REG_MAX_STEP: max_step = 32'(value);
         REG_WEIGHT:   weight = value[16:0];
         REG_OFFSET:   offset = longint'(signed'(value[16:0]));
      endcase
   endtask

   function automatic req_type make_sample(logic [31:0] t, int rate, int ax, int az, bit ok);
      req_type s;
      s.sample_time_us = t;
      s.gyro_rate = rate[15:0];
      s.accel_x = ax[15:0];
      s.accel_z = az[15:0];
      s.accel_plausible = ok;
      return s;
   endfunction

   // extremes, restarts and window edges at reset settings
   task automatic test_directed;
      send_sample(make_sample(32'd0, 100, 0, 0, 1));          // zero stamp, stays idle
      send_sample(make_sample(32'd1000, 32767, 0, 0, 1));     // first start, zero vector
      send_sample(make_sample(32'd1500, -32768, 32767, 32767, 0));  // step at minimum
      send_sample(make_sample(32'd51500, 32767, -32768, 16384, 1)); // step at maximum
      send_sample(make_sample(32'd51999, 5, 100, 100, 1));    // below window
      send_sample(make_sample(32'd102000, 5, 100, 100, 1));   // above window
      send_sample(make_sample(32'd103000, 1, 32767, -32768, 1));    // z<0, x>=0
      send_sample(make_sample(32'd104000, -1, -32768, -32768, 1));  // z<0, x<0
      send_sample(make_sample(32'd105000, 0, 0, -1, 1));
      send_sample(make_sample(32'd106000, 0, -1, 0, 0));
      send_sample(make_sample(32'd107000, -32768, 0, 32767, 1));
      send_sample(make_sample(32'hFFFF_FE00, 10, 20, 30, 1)); // far off, restart
      send_sample(make_sample(32'h0000_0100, 32767, 20, 30, 1));    // wraps through zero
      send_sample(make_sample(32'h0000_0000, 9, 7, 7, 1));   // zero stamp, not started
      send_sample(make_sample(32'h8000_0000, 9, 7, 7, 1));
      stamp = 32'h8000_0000;
   endtask

   // mostly in-window sample streams, with restarts and noise
   task automatic test_random(int count);
      req_type s;
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) stamp = $urandom();
         else if (pick < 7) stamp = 32'd0;
         else if (pick < 14) stamp = stamp + $urandom_range(0, 32'h1FFFFF);
         else if (min_step <= max_step) stamp = stamp + $urandom_range(max_step, min_step);
         else stamp = stamp + $urandom_range(0, 32'hFFFFF);
         s.sample_time_us = stamp;
         s.gyro_rate = 16'($urandom());
         s.accel_x = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3) - 2)
                                                 : 16'($urandom());
         s.accel_z = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 3) - 2)
                                                 : 16'($urandom());
         s.accel_plausible = $urandom_range(0, 7) != 0;
         send_sample(s);
         if (n == count / 2) drain();
      end
   endtask

   task automatic test_wide_window;
      write_reg(REG_MIN_STEP, 20'd0);
      write_reg(REG_MAX_STEP, 20'hFFFFF);
      write_reg(REG_WEIGHT, 20'h1FFFF);                       // above one, clamped
      write_reg(REG_OFFSET, 20'h0FFFF);                       // largest positive
      test_random(130);
   endtask

   task automatic test_accel_only;
      write_reg(REG_WEIGHT, 20'd0);
      write_reg(REG_OFFSET, 20'h10000);                       // most negative
      write_reg(REG_MIN_STEP, 20'd100);
      write_reg(REG_MAX_STEP, 20'd2000);
      test_random(130);
   endtask

   task automatic test_inverted_window;
      write_reg(REG_MIN_STEP, 20'd3000);
      write_reg(REG_MAX_STEP, 20'd1000);                      // nothing in window
      write_reg(REG_WEIGHT, 20'd65536);
      write_reg(REG_OFFSET, 20'd46080);
      test_random(60);
   endtask

   task automatic test_mixed_weight;
      write_reg(REG_MIN_STEP, 20'd1);
      write_reg(REG_MAX_STEP, 20'd100000);
      write_reg(REG_WEIGHT, 20'd32768);
      write_reg(REG_OFFSET, 20'h1_4C00);                      // -46080
      quiet = 1;
      test_random(60);
      quiet = 0;
      test_random(70);
   endtask

   initial begin
      last_stamp = '0;
      pitch_state = 0;
      min_step = 32'd500;
      max_step = 32'd50000;
      weight = 64225;
      offset = 0;
      stamp = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(185);
      test_wide_window();
      test_accel_only();
      test_inverted_window();
      test_mixed_weight();
      drain();
      repeat (30) @(posedge clock);
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   initial begin
      #8000000;
      $display("Some tests failed");
      $finish;
   end
endmodule
`default_nettype wire
